// ===== rtl/ert_pkg.sv =====
// ----------------------------------------------------------------------------
// ert_pkg
// Shared constants and types of the executable region table: table size,
// request kinds, status codes, and the probe and update records that run
// along the row of entry cells.
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int SPACE_W  = 32;
    localparam int ADDR_W   = 64;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 5;

    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FORGET = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_EXEC  = 3'd4;

    // search token passed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [SPACE_W-1:0] space;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
    } t_probe;

    // entry update broadcast to all cells
    typedef struct packed {
        logic               valid;
        logic               clear;
        logic [IDX_W-1:0]   idx;
        logic [SPACE_W-1:0] space;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
    } t_commit;

endpackage

// ===== rtl/ert_cell.sv =====
// ----------------------------------------------------------------------------
// ert_cell
// One table entry. Holds used bit, space identity and region, updates the
// passing probe with a match or a free slot, and registers it for the next
// cell.
// ----------------------------------------------------------------------------
module ert_cell import ert_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_probe           i_probe,
    input  t_commit          i_commit,
    output t_probe           o_probe
);

    logic               r_used;
    logic [SPACE_W-1:0] r_space;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_length;
    t_probe             r_probe;
    t_probe             n_probe;
    logic               w_match;

    assign w_match = r_used && (r_space == i_probe.space);

    always_comb begin
        n_probe = i_probe;
        if (w_match && !i_probe.hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = i_cell_idx;
            n_probe.base    = r_base;
            n_probe.length  = r_length;
        end
        if (!r_used && !i_probe.free_found) begin
            n_probe.free_found = 1'b1;
            n_probe.free_idx   = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= 1'b0;
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (i_commit.valid && (i_commit.idx == i_cell_idx)) begin
                r_used <= !i_commit.clear;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.valid && !i_commit.clear && (i_commit.idx == i_cell_idx)) begin
            r_space  <= i_commit.space;
            r_base   <= i_commit.base;
            r_length <= i_commit.length;
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/ert_ctrl.sv =====
// ----------------------------------------------------------------------------
// ert_ctrl
// Request sequencer. Takes a request, launches a probe into the cell row,
// decides the outcome when the probe leaves the last cell, issues the entry
// update, keeps the live count and holds the result register.
// ----------------------------------------------------------------------------
module ert_ctrl import ert_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SPACE_W-1:0]  i_space_id,
    input  logic [ADDR_W-1:0]   i_region_base,
    input  logic [ADDR_W-1:0]   i_region_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_refuse,
    output logic [ADDR_W-1:0]   o_found_base,
    output logic [ADDR_W-1:0]   o_found_length,
    output logic [LIVE_W-1:0]   o_live_entries,
    output t_probe              o_probe,
    input  t_probe              i_probe,
    output t_commit             o_commit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [KIND_W-1:0]   r_kind;
    logic [SPACE_W-1:0]  r_space;
    logic [ADDR_W-1:0]   r_base;
    logic [ADDR_W-1:0]   r_length;
    logic                r_launch;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_refuse;
    logic [ADDR_W-1:0]   r_res_base;
    logic [ADDR_W-1:0]   r_res_length;
    logic [LIVE_W-1:0]   r_res_live;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_refuse;
    logic [ADDR_W-1:0]   r_out_base;
    logic [ADDR_W-1:0]   r_out_length;
    logic [LIVE_W-1:0]   r_out_live;

    logic                w_accept;
    logic                w_done;
    logic                w_invalid;
    logic                w_write;
    logic                w_clear;
    logic [IDX_W-1:0]    w_idx;
    logic [STATUS_W-1:0] w_status;
    logic                w_refuse;
    logic [ADDR_W-1:0]   w_base;
    logic [ADDR_W-1:0]   w_length;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_done     = (r_state == S_SCAN) && i_probe.valid;
    assign w_invalid  = (r_space == '0);

    always_comb begin
        w_status = ST_OK;
        w_refuse = 1'b0;
        w_base   = '0;
        w_length = '0;
        w_write  = 1'b0;
        w_clear  = 1'b0;
        w_idx    = i_probe.free_idx;
        n_count  = r_count;
        case (r_kind)
            KIND_CHECK: begin
                w_refuse = w_invalid || i_probe.hit;
            end
            KIND_RECORD: begin
                if (w_invalid || (r_length == '0)) begin
                    w_status = ST_INVALID;
                end else if (i_probe.hit) begin
                    w_status = ST_ALREADY;
                end else if (!i_probe.free_found) begin
                    w_status = ST_EXHAUSTED;
                end else begin
                    w_write = 1'b1;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            KIND_LOOKUP: begin
                if (w_invalid) begin
                    w_status = ST_INVALID;
                end else if (!i_probe.hit) begin
                    w_status = ST_NOT_EXEC;
                end else begin
                    w_base   = i_probe.base;
                    w_length = i_probe.length;
                end
            end
            KIND_FORGET: begin
                if (w_invalid) begin
                    w_status = ST_INVALID;
                end else if (i_probe.hit) begin
                    w_write = 1'b1;
                    w_clear = 1'b1;
                    w_idx   = i_probe.hit_idx;
                    if (r_count != '0) begin
                        n_count = CNT_W'(r_count - 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_commit.valid  = w_done && w_write;
        o_commit.clear  = w_clear;
        o_commit.idx    = w_idx;
        o_commit.space  = r_space;
        o_commit.base   = r_base;
        o_commit.length = r_length;
    end

    always_comb begin
        o_probe            = '0;
        o_probe.valid      = r_launch;
        o_probe.space      = r_space;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= w_accept;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= i_kind;
                        r_space  <= i_space_id;
                        r_base   <= i_region_base;
                        r_length <= i_region_length;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_count      <= n_count;
                        r_res_status <= w_status;
                        r_res_refuse <= w_refuse;
                        r_res_base   <= w_base;
                        r_res_length <= w_length;
                        r_res_live   <= LIVE_W'(n_count);
                        r_state      <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_refuse <= r_res_refuse;
                        r_out_base   <= r_res_base;
                        r_out_length <= r_res_length;
                        r_out_live   <= r_res_live;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_refuse       = r_out_refuse;
    assign o_found_base   = r_out_base;
    assign o_found_length = r_out_length;
    assign o_live_entries = r_out_live;

endmodule

// ===== rtl/executable_region_table_top.sv =====
// ----------------------------------------------------------------------------
// executable_region_table_top
// Table of executable regions, one per address-space identity, built as a
// row of entry cells searched by a probe that moves one cell per cycle.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries kind, space identity,
//   region base and length. Result channel (o_out_valid / i_out_ready)
//   carries status, refuse flag, found region and the live entry count.
//   Exactly one result per request, in request order.
//   One request is handled at a time. A transfer on the request side
//   launches a probe through the TABLE_ENTRIES cells; the outcome and the
//   entry update follow when it leaves the last cell. The outcome is
//   registered in the result holding registers and from there loaded
//   into the output register, after which o_in_ready returns high.
//   A pending result may wait in the output register while the next
//   request is taken; a stalled receiver then holds that request in its
//   final step until the output register frees up.
//   Reset clears all entry used bits, the live count and both handshakes.
// ----------------------------------------------------------------------------
module executable_region_table_top import ert_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SPACE_W-1:0]  i_space_id,
    input  logic [ADDR_W-1:0]   i_region_base,
    input  logic [ADDR_W-1:0]   i_region_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_refuse,
    output logic [ADDR_W-1:0]   o_found_base,
    output logic [ADDR_W-1:0]   o_found_length,
    output logic [LIVE_W-1:0]   o_live_entries
);

    t_probe  w_probe [TABLE_ENTRIES+1];
    t_commit w_commit;

    ert_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_space_id      (i_space_id),
        .i_region_base   (i_region_base),
        .i_region_length (i_region_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_refuse        (o_refuse),
        .o_found_base    (o_found_base),
        .o_found_length  (o_found_length),
        .o_live_entries  (o_live_entries),
        .o_probe         (w_probe[0]),
        .i_probe         (w_probe[TABLE_ENTRIES]),
        .o_commit        (w_commit)
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ert_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_probe    (w_probe[g]),
            .i_commit   (w_commit),
            .o_probe    (w_probe[g+1])
        );
    end

endmodule

// ===== rtl/ert_checker.sv =====
// ----------------------------------------------------------------------------
// ert_checker
// Port-level checks of the executable region table, bound to the top level.
// ----------------------------------------------------------------------------
module ert_checker import ert_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic                o_refuse,
    input logic [ADDR_W-1:0]   o_found_base,
    input logic [ADDR_W-1:0]   o_found_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    a_refuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refuse |-> o_status == ST_OK)
        else $error("refuse flag with non-ok status");

    a_miss_no_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_found_base == '0) && (o_found_length == '0))
        else $error("region reported on failed request");

endmodule

bind executable_region_table_top ert_checker u_ert_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_refuse       (o_refuse),
    .o_found_base   (o_found_base),
    .o_found_length (o_found_length)
);
